// ===== rtl/kar_pkg.sv =====
// kar_pkg: shared widths, codes and reset values for the key auto-repeat block.
// No dependencies; imported by key_auto_repeat.
package kar_pkg;

    localparam int KAR_W         = 16;  // width of masks, counters and registers
    localparam int KAR_KEY_BITS  = 16;  // default number of key lines
    localparam int KAR_CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [KAR_CFG_IDX_W-1:0] CFG_REPEAT_TICKS    = 3'd0;
    localparam logic [KAR_CFG_IDX_W-1:0] CFG_DELAY_TICKS     = 3'd1;
    localparam logic [KAR_CFG_IDX_W-1:0] CFG_SETTLE_TICKS    = 3'd2;
    localparam logic [KAR_CFG_IDX_W-1:0] CFG_REPEAT_KEY_MASK = 3'd3;
    localparam logic [KAR_CFG_IDX_W-1:0] CFG_CLOCK_PERIOD    = 3'd4;

    // reset values
    localparam logic [KAR_W-1:0] RST_REPEAT_TICKS    = 16'd25;
    localparam logic [KAR_W-1:0] RST_DELAY_TICKS     = 16'd500;
    localparam logic [KAR_W-1:0] RST_SETTLE_TICKS    = 16'd5;
    localparam logic [KAR_W-1:0] RST_REPEAT_KEY_MASK = 16'd15;
    localparam logic [KAR_W-1:0] RST_CLOCK_PERIOD    = 16'd1000;

    // input item kinds
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SCAN = 1'b1;

    // result item kinds
    localparam logic EVT_BUTTON = 1'b0;
    localparam logic EVT_CLOCK  = 1'b1;

endpackage

// ===== rtl/key_auto_repeat.sv =====
// key_auto_repeat: button auto-repeat engine with millisecond clock divider.
// Depends on kar_pkg for widths, codes and reset values.
//
// Usage:
//   Input stream s_axis: one item per tick or key scan. tuser carries the
//   kind (tick or scan), tdata the pressed-key mask (ignored on a tick).
//   Output stream m_axis: zero or one item per input item. tuser carries the
//   event kind (button change or clock), tdata the changed keys and the new
//   held mask; a clock event carries zero masks.
//   Configuration: cfg_we/cfg_index/cfg_data write one 16-bit register per
//   cycle; write only while no item is in flight.
// Timing:
//   An accepted item lands in an input register and is evaluated there once
//   the output register is free or being taken; the result goes into the
//   output register (m_axis_tvalid). One item per cycle is sustained while
//   m_axis_tready is high; the input register directly feeds the output one.
// Reset: all counters, the held mask and the repeat flag clear; registers
//   take their default values. When the receiver stalls, the output register
//   holds its item and the input register still takes one more item before
//   s_axis_tready drops.
module key_auto_repeat
    import kar_pkg::*;
#(
    parameter int KEY_BITS = KAR_KEY_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // slave side
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [KAR_W-1:0]         s_axis_tdata,   // [15:0] pressed_keys
    input  logic [0:0]               s_axis_tuser,   // [0] op
    // master side
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [2*KAR_W-1:0]       m_axis_tdata,   // [15:0] changed_keys, [31:16] held_keys
    output logic [0:0]               m_axis_tuser,   // [0] event_kind
    // configuration
    input  logic                     cfg_we,
    input  logic [KAR_CFG_IDX_W-1:0] cfg_index,
    input  logic [KAR_W-1:0]         cfg_data
);

    localparam int KeyBitsLim = (KEY_BITS >= KAR_W) ? KAR_W : KEY_BITS;
    localparam logic [KAR_W-1:0] KeyMask =
        (KEY_BITS >= KAR_W) ? {KAR_W{1'b1}} : KAR_W'((32'd1 << KeyBitsLim) - 32'd1);

    // configuration registers
    logic [KAR_W-1:0] repeat_ticks_reg;
    logic [KAR_W-1:0] delay_ticks_reg;
    logic [KAR_W-1:0] settle_ticks_reg;
    logic [KAR_W-1:0] repeat_key_mask_reg;
    logic [KAR_W-1:0] clock_period_reg;

    // engine state
    logic [KAR_W-1:0] tick_count_reg,  tick_count_next;
    logic [KAR_W-1:0] divider_reg,     divider_next;
    logic [KAR_W-1:0] last_event_reg,  last_event_next;
    logic [KAR_W-1:0] held_mask_reg,   held_mask_next;
    logic             repeating_reg,   repeating_next;

    // input register
    logic             in_valid_reg;
    logic             in_op_reg;
    logic [KAR_W-1:0] in_keys_reg;

    // output register
    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [KAR_W-1:0] out_changed_reg;
    logic [KAR_W-1:0] out_held_reg;

    logic             res_valid;
    logic             res_kind;
    logic [KAR_W-1:0] res_changed;
    logic [KAR_W-1:0] res_held;

    logic             advance;
    logic [KAR_W:0]   div_inc;
    logic [KAR_W-1:0] period_eff;
    logic [KAR_W-1:0] now_mask;
    logic [KAR_W-1:0] send_mask;
    logic [KAR_W-1:0] elapsed;
    logic             due;
    logic             rep_after;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {out_held_reg, out_changed_reg};

    always_comb
    begin
        div_inc    = {1'b0, divider_reg} + {{KAR_W{1'b0}}, 1'b1};
        period_eff = (clock_period_reg == '0) ? KAR_W'(1) : clock_period_reg;
        now_mask   = in_keys_reg & KeyMask;
        send_mask  = (now_mask ^ held_mask_reg) | (now_mask & repeat_key_mask_reg);
        elapsed    = tick_count_reg - last_event_reg;

        if (now_mask == held_mask_reg)
        begin
            // same mask: first repeat after the delay, then at the repeat rate
            due       = repeating_reg ? (elapsed > repeat_ticks_reg)
                                      : (elapsed > delay_ticks_reg);
            rep_after = 1'b1;
        end
        else
        begin
            due       = elapsed > settle_ticks_reg;
            rep_after = 1'b0;
        end

        tick_count_next = tick_count_reg;
        divider_next    = divider_reg;
        last_event_next = last_event_reg;
        held_mask_next  = held_mask_reg;
        repeating_next  = repeating_reg;
        res_valid       = 1'b0;
        res_kind        = EVT_BUTTON;
        res_changed     = '0;
        res_held        = '0;

        if (in_op_reg == OP_TICK)
        begin
            tick_count_next = tick_count_reg + KAR_W'(1);
            if (div_inc >= {1'b0, period_eff})
            begin
                divider_next = '0;
                res_valid    = 1'b1;
                res_kind     = EVT_CLOCK;
            end
            else
            begin
                divider_next = div_inc[KAR_W-1:0];
            end
        end
        else if (due && send_mask != '0)
        begin
            repeating_next  = rep_after;
            last_event_next = tick_count_reg;
            held_mask_next  = now_mask;
            res_valid       = 1'b1;
            res_kind        = EVT_BUTTON;
            res_changed     = send_mask;
            res_held        = now_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_ticks_reg    <= RST_REPEAT_TICKS;
            delay_ticks_reg     <= RST_DELAY_TICKS;
            settle_ticks_reg    <= RST_SETTLE_TICKS;
            repeat_key_mask_reg <= RST_REPEAT_KEY_MASK;
            clock_period_reg    <= RST_CLOCK_PERIOD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REPEAT_TICKS:    repeat_ticks_reg    <= cfg_data;
                CFG_DELAY_TICKS:     delay_ticks_reg     <= cfg_data;
                CFG_SETTLE_TICKS:    settle_ticks_reg    <= cfg_data;
                CFG_REPEAT_KEY_MASK: repeat_key_mask_reg <= cfg_data;
                CFG_CLOCK_PERIOD:    clock_period_reg    <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            divider_reg    <= '0;
            last_event_reg <= '0;
            held_mask_reg  <= '0;
            repeating_reg  <= 1'b0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end

            if (advance)
            begin
                tick_count_reg <= tick_count_next;
                divider_reg    <= divider_next;
                last_event_reg <= last_event_next;
                held_mask_reg  <= held_mask_next;
                repeating_reg  <= repeating_next;
                out_valid_reg  <= res_valid;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg   <= s_axis_tuser[0];
            in_keys_reg <= s_axis_tdata;
        end
        if (advance && res_valid)
        begin
            out_kind_reg    <= res_kind;
            out_changed_reg <= res_changed;
            out_held_reg    <= res_held;
        end
    end

endmodule
